FILE: hw/rtl/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg
// Shared constants, types and helpers of the matrix row/column rotator.
// ----------------------------------------------------------------------------
package mrr_pkg;

    // matrix geometry
    localparam int MAX_DIM   = 32;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int SIZE_W    = 6;
    localparam int WORD_W    = 32;
    localparam int SHIFT_W   = 16;
    localparam int STEP_W    = $clog2(SHIFT_W);

    // stream widths
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 32;
    localparam int CFG_IDX_W = 2;

    // command codes
    localparam logic [2:0] ACT_LOAD      = 3'd0;
    localparam logic [2:0] ACT_ROW_RIGHT = 3'd1;
    localparam logic [2:0] ACT_ROW_LEFT  = 3'd2;
    localparam logic [2:0] ACT_COL_UP    = 3'd3;
    localparam logic [2:0] ACT_COL_DOWN  = 3'd4;
    localparam logic [2:0] ACT_READ      = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

    // input item as packed in s_tdata, lowest field last
    typedef struct packed {
        logic [5:0]         pad;
        logic [WORD_W-1:0]  value;
        logic [SHIFT_W-1:0] shift_amount;
        logic [IDX_W-1:0]   col_index;
        logic [IDX_W-1:0]   row_index;
        logic [IDX_W-1:0]   line_index;
        logic [2:0]         action;
    } in_item_t;

    // modulo unit request and response
    typedef struct packed {
        logic               start;
        logic [SHIFT_W-1:0] dividend;
        logic [SIZE_W-1:0]  divisor;
    } mod_req_t;

    typedef struct packed {
        logic               done;
        logic [IDX_W-1:0]   rem;
    } mod_rsp_t;

    // size register saturated to the storage dimension
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] lim;
        lim = SIZE_W'(MAX_DIM);
        return (sz > lim) ? lim : sz;
    endfunction

endpackage

FILE: hw/rtl/mrr_ram.sv
// ----------------------------------------------------------------------------
// mrr_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module mrr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write, or read into the output register (held otherwise)
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/mrr_mod_unit.sv
// ----------------------------------------------------------------------------
// mrr_mod_unit
// Bit-serial remainder of the rotation amount by the line length,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mrr_mod_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  mrr_pkg::mod_req_t req,
    output mrr_pkg::mod_rsp_t rsp
);

    logic                             busy_reg,  busy_next;
    logic                             done_reg,  done_next;
    logic [mrr_pkg::STEP_W-1:0]       step_reg,  step_next;
    logic [mrr_pkg::SHIFT_W-1:0]      quo_reg,   quo_next;
    logic [mrr_pkg::IDX_W-1:0]        rem_reg,   rem_next;
    logic [mrr_pkg::SIZE_W-1:0]       div_reg,   div_next;
    logic [mrr_pkg::IDX_W:0]          trial;
    logic [mrr_pkg::IDX_W:0]          diff;

    // one restoring step: remainder stays below the divisor
    assign trial = {rem_reg, quo_reg[mrr_pkg::SHIFT_W-1]};
    assign diff  = trial - (mrr_pkg::IDX_W+1)'(div_reg);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        priority if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[mrr_pkg::SHIFT_W-2:0], 1'b0};
            rem_next = ((mrr_pkg::IDX_W+1)'(div_reg) <= trial) ?
                       diff[mrr_pkg::IDX_W-1:0] : trial[mrr_pkg::IDX_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == mrr_pkg::STEP_W'(mrr_pkg::SHIFT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: hw/rtl/matrix_row_column_rotator.sv
// ----------------------------------------------------------------------------
// matrix_row_column_rotator
// Matrix of signed words in a single-port RAM with element load/read and
// circular rotation of one row or one column through a line buffer RAM.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  s_*       in         s_tvalid / s_tready       s_tdata: command item
//  m_*       out        m_tvalid / m_tready       m_tdata: read value, m_tuser: status
//  cfg_*     in         cfg_valid / cfg_ready     cfg_index, cfg_wdata: size registers
//
//  load, read and rejected commands go from acceptance to the response state
//  and from there into the output register. a rotation of a line first runs
//  the bit-serial modulo and its handoff, then copies the line out of the
//  matrix RAM into the line buffer, then writes it back, the matrix RAM
//  having a single port, and last loads the output register.
//  one command is in work at a time; the next is taken while a result waits.
//  reset returns the sizes to 32 x 32; matrix contents are not cleared.
//  a stalled output only holds the sequencer in its response state.
// ----------------------------------------------------------------------------
module matrix_row_column_rotator (
    input  logic                            aclk,
    input  logic                            aresetn,
    // command stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action, line_index, row_index, col_index, shift_amount, value, zero fill
    input  logic [mrr_pkg::S_TDATA_W-1:0]   s_tdata,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_value
    output logic [mrr_pkg::M_TDATA_W-1:0]   m_tdata,
    // status
    output logic [0:0]                      m_tuser,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mrr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mrr_pkg::SIZE_W-1:0]      cfg_wdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MOD  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;

    localparam int IW = mrr_pkg::IDX_W;
    localparam int SW = mrr_pkg::SIZE_W;

    mrr_pkg::in_item_t   item;
    mrr_pkg::mod_req_t   mod_req;
    mrr_pkg::mod_rsp_t   mod_rsp;

    logic [2:0]          state_reg,   state_next;
    logic [SW-1:0]       rows_reg,    cols_reg;
    logic                err_reg,     err_next;
    logic                rd_reg,      rd_next;
    logic                row_reg,     row_next;
    logic                inv_reg,     inv_next;
    logic [IW-1:0]       line_reg,    line_next;
    logic [SW-1:0]       len_reg,     len_next;
    logic [SW-1:0]       cnt_reg,     cnt_next;
    logic [IW-1:0]       dst_reg,     dst_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [mrr_pkg::WORD_W-1:0] m_data_reg, m_data_next;
    logic                m_status_reg, m_status_next;

    logic [SW-1:0]       nr, nc;
    logic                accept, is_elem, is_rowrot, is_colrot, acc_err;
    logic                out_free;
    logic [IW-1:0]       cnt_m1;
    logic [IW-1:0]       dst_inc;
    logic [IW-1:0]       k_rot;

    logic                      mem_en, mem_we;
    logic [mrr_pkg::ADDR_W-1:0] mem_addr;
    logic [mrr_pkg::WORD_W-1:0] mem_wdata, mem_rdata;
    logic                      buf_en, buf_we;
    logic [IW-1:0]             buf_addr;
    logic [mrr_pkg::WORD_W-1:0] buf_wdata, buf_rdata;

    // matrix RAM, element (r,c) at {r,c}
    mrr_ram #(.WIDTH(mrr_pkg::WORD_W), .DEPTH(mrr_pkg::DEPTH)) u_matrix (
        .aclk(aclk), .en(mem_en), .we(mem_we), .addr(mem_addr),
        .wdata(mem_wdata), .rdata(mem_rdata)
    );

    // line buffer RAM, holds the rotated line
    mrr_ram #(.WIDTH(mrr_pkg::WORD_W), .DEPTH(mrr_pkg::MAX_DIM)) u_line_buf (
        .aclk(aclk), .en(buf_en), .we(buf_we), .addr(buf_addr),
        .wdata(buf_wdata), .rdata(buf_rdata)
    );

    mrr_mod_unit u_mod (
        .aclk(aclk), .aresetn(aresetn), .req(mod_req), .rsp(mod_rsp)
    );

    // handshakes
    assign item      = mrr_pkg::in_item_t'(s_tdata);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // command decode and range check
    assign nr        = mrr_pkg::eff_size(rows_reg);
    assign nc        = mrr_pkg::eff_size(cols_reg);
    assign is_elem   = (item.action == mrr_pkg::ACT_LOAD) || (item.action == mrr_pkg::ACT_READ);
    assign is_rowrot = (item.action == mrr_pkg::ACT_ROW_RIGHT) ||
                       (item.action == mrr_pkg::ACT_ROW_LEFT);
    assign is_colrot = (item.action == mrr_pkg::ACT_COL_UP) ||
                       (item.action == mrr_pkg::ACT_COL_DOWN);

    always_comb begin
        priority if (nr == '0 || nc == '0) begin
            acc_err = 1'b1;
        end else if (is_elem) begin
            acc_err = ({1'b0, item.row_index} >= nr) || ({1'b0, item.col_index} >= nc);
        end else if (is_rowrot) begin
            acc_err = ({1'b0, item.line_index} >= nr);
        end else if (is_colrot) begin
            acc_err = ({1'b0, item.line_index} >= nc);
        end else begin
            acc_err = 1'b1;
        end
    end

    // modulo request on an accepted, in-range rotation
    assign mod_req.start    = accept && !acc_err && (is_rowrot || is_colrot);
    assign mod_req.dividend = item.shift_amount;
    assign mod_req.divisor  = is_rowrot ? nc : nr;

    // left and up rotations turn into n - k toward higher positions
    always_comb begin
        k_rot = mod_rsp.rem;
        if (inv_reg && (mod_rsp.rem != '0)) begin
            k_rot = IW'(len_reg - SW'(mod_rsp.rem));
        end
    end

    assign cnt_m1  = IW'(cnt_reg - 1'b1);
    assign dst_inc = ({1'b0, dst_reg} + 1'b1 == len_reg) ? '0 : IW'(dst_reg + 1'b1);

    // memory port control
    always_comb begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = item.value;
        buf_en    = 1'b0;
        buf_we    = 1'b0;
        buf_addr  = '0;
        buf_wdata = mem_rdata;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !acc_err && is_elem) begin
                    mem_en   = 1'b1;
                    mem_we   = (item.action == mrr_pkg::ACT_LOAD);
                    mem_addr = {item.row_index, item.col_index};
                end
            end
            ST_RD: begin
                // read position cnt, store the previous one at its new place
                if (cnt_reg < len_reg) begin
                    mem_en   = 1'b1;
                    mem_addr = row_reg ? {line_reg, cnt_reg[IW-1:0]}
                                       : {cnt_reg[IW-1:0], line_reg};
                end
                if (cnt_reg != '0) begin
                    buf_en   = 1'b1;
                    buf_we   = 1'b1;
                    buf_addr = dst_reg;
                end
            end
            ST_WR: begin
                // read buffer entry cnt, write back the previous one
                if (cnt_reg < len_reg) begin
                    buf_en   = 1'b1;
                    buf_addr = cnt_reg[IW-1:0];
                end
                if (cnt_reg != '0) begin
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_addr  = row_reg ? {line_reg, cnt_m1} : {cnt_m1, line_reg};
                    mem_wdata = buf_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        err_next      = err_reg;
        rd_next       = rd_reg;
        row_next      = row_reg;
        inv_next      = inv_reg;
        line_next     = line_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        dst_next      = dst_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    err_next   = acc_err;
                    rd_next    = (item.action == mrr_pkg::ACT_READ);
                    row_next   = is_rowrot;
                    inv_next   = (item.action == mrr_pkg::ACT_ROW_LEFT) ||
                                 (item.action == mrr_pkg::ACT_COL_UP);
                    line_next  = item.line_index;
                    len_next   = is_rowrot ? nc : nr;
                    state_next = mod_req.start ? ST_MOD : ST_RESP;
                end
            end
            ST_MOD: begin
                if (mod_rsp.done) begin
                    dst_next   = k_rot;
                    cnt_next   = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                if (cnt_reg != '0) begin
                    dst_next = dst_inc;
                end
                if (cnt_reg == len_reg) begin
                    cnt_next   = '0;
                    state_next = ST_WR;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_WR: begin
                if (cnt_reg == len_reg) begin
                    state_next = ST_RESP;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = (rd_reg && !err_reg) ? mem_rdata : '0;
                    m_status_next = err_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            rows_reg     <= SW'(mrr_pkg::MAX_DIM);
            cols_reg     <= SW'(mrr_pkg::MAX_DIM);
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
            // size register writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == mrr_pkg::CFG_ROWS) begin
                    rows_reg <= cfg_wdata;
                end else if (cfg_index == mrr_pkg::CFG_COLS) begin
                    cols_reg <= cfg_wdata;
                end
            end
        end
        err_reg      <= err_next;
        rd_reg       <= rd_next;
        row_reg      <= row_next;
        inv_reg      <= inv_next;
        line_reg     <= line_next;
        len_reg      <= len_next;
        dst_reg      <= dst_next;
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_status_reg;

    // every accepted command takes the sequencer out of idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted while another still in work");

    // an ignored command never returns data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("error result carries nonzero data");

    // the modulo result arrives only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        mod_rsp.done |-> state_reg == ST_MOD)
        else $error("modulo done outside its wait state");

    // line copy counters stay within the line length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD || state_reg == ST_WR) |-> cnt_reg <= len_reg)
        else $error("line counter beyond line length");

endmodule
